[src/psf2utp_pkg.sv]
// ----------------------------------------------------------------------------
// psf2utp_pkg
// Shared types, constants and helpers of the PSF2 unicode-table parser.
// ----------------------------------------------------------------------------
package psf2utp_pkg;

  localparam int unsigned GLYPH_INDEX_WIDTH = 16;
  localparam int unsigned GLYPH_BYTES_WIDTH = 13;
  localparam int unsigned CODEPOINT_WIDTH   = 21;
  localparam int unsigned OFFSET_WIDTH      = 28;
  localparam int unsigned PRODUCT_WIDTH     = GLYPH_INDEX_WIDTH + GLYPH_BYTES_WIDTH;

  localparam logic [7:0] SEQ_START_BYTE = 8'hFE;
  localparam logic [7:0] SEPARATOR_BYTE = 8'hFF;

  localparam logic [GLYPH_BYTES_WIDTH-1:0] GLYPH_BYTES_RESET = GLYPH_BYTES_WIDTH'(16);
  localparam logic [GLYPH_INDEX_WIDTH-1:0] GLYPH_INDEX_MAX   = '1;

  // Two-entry queues: one index bit, count holds 0..2.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] table_byte;
    logic       end_of_table;
  } in_item_t;

  typedef struct packed {
    logic                       entry_valid;
    logic [CODEPOINT_WIDTH-1:0] codepoint;
    logic [OFFSET_WIDTH-1:0]    glyph_offset;
    logic                       invalid_seen;
    logic                       sequence_stop;
    logic                       index_saturated;
  } out_item_t;

  // Classified byte handed from the front to the back.
  typedef struct packed {
    logic                         entry_valid;
    logic [CODEPOINT_WIDTH-1:0]   codepoint;
    logic [GLYPH_INDEX_WIDTH-1:0] glyph_num;
    logic                         invalid_seen;
    logic                         sequence_stop;
    logic                         index_saturated;
  } mid_item_t;

  // UTF-8 sequence length from the lead byte, 0 for a bad lead.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0)            len = 3'd1;
    else if (b[7:5] == 3'b110)   len = 3'd2;
    else if (b[7:4] == 4'b1110)  len = 3'd3;
    else if (b[7:3] == 5'b11110) len = 3'd4;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

[src/psf2_unicode_table_parser.sv]
// ----------------------------------------------------------------------------
// psf2_unicode_table_parser
// PSF2 unicode-table parser: one table byte in, one mapping result out.
// ----------------------------------------------------------------------------
// Path: the front classifies each byte into the queue, then the back
//   multiplies it into the result buffer, from which the result is popped.
// Throughput: 1 byte per cycle while full is low, with a single offset multiplier.
// Reset: parser state and both queues clear; glyph_bytes returns to 16.
// The configuration write is always ready.
module psf2_unicode_table_parser (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [psf2utp_pkg::GLYPH_BYTES_WIDTH-1:0] cfg_glyph_bytes_i,
  input  logic                                      push,
  output logic                                      full,
  input  psf2utp_pkg::in_item_t                     in_item_i,
  output logic                                      empty,
  input  logic                                      pop,
  output psf2utp_pkg::out_item_t                    out_item_o
);

  logic                   accept;
  logic                   mid_empty, mid_pop;
  psf2utp_pkg::mid_item_t front_item, mid_item;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  psf2utp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .item_o   (front_item)
  );

  psf2utp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .item_o  (mid_item),
    .empty_o (mid_empty)
  );

  psf2utp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_glyph_bytes_i (cfg_glyph_bytes_i),
    .mid_empty_i       (mid_empty),
    .mid_item_i        (mid_item),
    .mid_pop_o         (mid_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .item_o            (out_item_o)
  );

endmodule

[src/psf2utp_front.sv]
// ----------------------------------------------------------------------------
// psf2utp_front
// Byte classifier: UTF-8 assembly, glyph index, sticky flags.
// ----------------------------------------------------------------------------
module psf2utp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  psf2utp_pkg::in_item_t  item_i,
  output psf2utp_pkg::mid_item_t item_o
);

  logic [7:0] pb_q [3];
  logic [7:0] pb_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic [psf2utp_pkg::GLYPH_INDEX_WIDTH-1:0] glyph_q, glyph_d;
  logic halted_q, halted_d;
  logic bad_q, bad_d;
  logic full_q, full_d;

  logic [7:0] b;
  logic [7:0] lead;
  logic [2:0] len;
  logic       cont_ok;
  logic [psf2utp_pkg::CODEPOINT_WIDTH-1:0] cp;

  assign b    = item_i.table_byte;
  assign lead = (cnt_q == 2'd0) ? b : pb_q[0];
  assign len  = psf2utp_pkg::lead_length(lead);

  always_comb begin
    cont_ok = 1'b1;
    cp      = '0;
    case (len)
      3'd1: begin
        cp = psf2utp_pkg::CODEPOINT_WIDTH'(b);
      end
      3'd2: begin
        cont_ok = psf2utp_pkg::is_cont(b);
        cp = psf2utp_pkg::CODEPOINT_WIDTH'({pb_q[0][4:0], b[5:0]});
      end
      3'd3: begin
        cont_ok = psf2utp_pkg::is_cont(pb_q[1]) && psf2utp_pkg::is_cont(b);
        cp = psf2utp_pkg::CODEPOINT_WIDTH'({pb_q[0][3:0], pb_q[1][5:0], b[5:0]});
      end
      3'd4: begin
        cont_ok = psf2utp_pkg::is_cont(pb_q[1]) && psf2utp_pkg::is_cont(pb_q[2])
                  && psf2utp_pkg::is_cont(b);
        cp = {pb_q[0][2:0], pb_q[1][5:0], pb_q[2][5:0], b[5:0]};
      end
      default: begin
        cont_ok = 1'b0;
        cp      = '0;
      end
    endcase
  end

  always_comb begin
    pb_d     = pb_q;
    cnt_d    = cnt_q;
    glyph_d  = glyph_q;
    halted_d = halted_q;
    bad_d    = bad_q;
    full_d   = full_q;
    item_o   = '0;

    if (!halted_q) begin
      if (b == psf2utp_pkg::SEQ_START_BYTE) begin
        halted_d = 1'b1;
      end else if (b == psf2utp_pkg::SEPARATOR_BYTE) begin
        if (cnt_q != 2'd0) begin
          bad_d = 1'b1;
        end
        cnt_d = 2'd0;
        if (glyph_q != psf2utp_pkg::GLYPH_INDEX_MAX) begin
          glyph_d = glyph_q + 1'b1;
        end
        if (glyph_d == psf2utp_pkg::GLYPH_INDEX_MAX) begin
          full_d = 1'b1;
        end
      end else if (len == 3'd0) begin
        bad_d = 1'b1;
        cnt_d = 2'd0;
      end else if (len == ({1'b0, cnt_q} + 3'd1)) begin
        // sequence complete
        if (cont_ok) begin
          item_o.entry_valid = 1'b1;
          item_o.codepoint   = cp;
          item_o.glyph_num   = glyph_q;
        end else begin
          bad_d = 1'b1;
        end
        cnt_d = 2'd0;
      end else begin
        case (cnt_q)
          2'd0:    pb_d[0] = b;
          2'd1:    pb_d[1] = b;
          2'd2:    pb_d[2] = b;
          default: pb_d[0] = pb_q[0];
        endcase
        cnt_d = cnt_q + 2'd1;
      end
    end

    item_o.invalid_seen    = bad_d;
    item_o.sequence_stop   = halted_d;
    item_o.index_saturated = full_d;

    if (item_i.end_of_table) begin
      cnt_d    = 2'd0;
      glyph_d  = '0;
      halted_d = 1'b0;
      bad_d    = 1'b0;
      full_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      glyph_q  <= '0;
      halted_q <= 1'b0;
      bad_q    <= 1'b0;
      full_q   <= 1'b0;
    end else if (accept_i) begin
      cnt_q    <= cnt_d;
      glyph_q  <= glyph_d;
      halted_q <= halted_d;
      bad_q    <= bad_d;
      full_q   <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pb_q <= pb_d;
    end
  end

endmodule

[src/psf2utp_queue.sv]
// ----------------------------------------------------------------------------
// psf2utp_queue
// Two-entry queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module psf2utp_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  psf2utp_pkg::mid_item_t item_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output psf2utp_pkg::mid_item_t item_o,
  output logic                   empty_o
);

  psf2utp_pkg::mid_item_t mem_q [psf2utp_pkg::QUEUE_DEPTH];
  logic [psf2utp_pkg::QUEUE_IDX_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [psf2utp_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == psf2utp_pkg::QUEUE_CNT_W'(psf2utp_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[src/psf2utp_back.sv]
// ----------------------------------------------------------------------------
// psf2utp_back
// Offset multiply (glyph index times glyph size) and result buffer.
// ----------------------------------------------------------------------------
module psf2utp_back (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_valid_i,
  input  logic [psf2utp_pkg::GLYPH_BYTES_WIDTH-1:0]  cfg_glyph_bytes_i,
  input  logic                                       mid_empty_i,
  input  psf2utp_pkg::mid_item_t                     mid_item_i,
  output logic                                       mid_pop_o,
  input  logic                                       pop_i,
  output logic                                       empty_o,
  output psf2utp_pkg::out_item_t                     item_o
);

  logic [psf2utp_pkg::GLYPH_BYTES_WIDTH-1:0] glyph_bytes_q;
  logic [psf2utp_pkg::PRODUCT_WIDTH-1:0]     product;
  psf2utp_pkg::out_item_t                    res;

  psf2utp_pkg::out_item_t buf_q [psf2utp_pkg::QUEUE_DEPTH];
  logic [psf2utp_pkg::QUEUE_IDX_W-1:0] wr_q, rd_q;
  logic [psf2utp_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic buf_full, do_write, do_pop;

  assign product = psf2utp_pkg::PRODUCT_WIDTH'(mid_item_i.glyph_num)
                 * psf2utp_pkg::PRODUCT_WIDTH'(glyph_bytes_q);

  always_comb begin
    res                 = '0;
    res.entry_valid     = mid_item_i.entry_valid;
    res.invalid_seen    = mid_item_i.invalid_seen;
    res.sequence_stop   = mid_item_i.sequence_stop;
    res.index_saturated = mid_item_i.index_saturated;
    if (mid_item_i.entry_valid) begin
      res.codepoint    = mid_item_i.codepoint;
      res.glyph_offset = product[psf2utp_pkg::OFFSET_WIDTH-1:0];
    end
  end

  assign buf_full  = (cnt_q == psf2utp_pkg::QUEUE_CNT_W'(psf2utp_pkg::QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_write  = !mid_empty_i && !buf_full;
  assign do_pop    = pop_i && !empty_o;
  assign mid_pop_o = do_write;
  assign item_o    = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_write && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_write && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_bytes_q <= psf2utp_pkg::GLYPH_BYTES_RESET;
      wr_q          <= '0;
      rd_q          <= '0;
      cnt_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        glyph_bytes_q <= cfg_glyph_bytes_i;
      end
      if (do_write) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      buf_q[wr_q] <= res;
    end
  end

endmodule

[tb/sv/psf2_unicode_table_parser_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf2_unicode_table_parser_test
// Self-checking bench for the PSF2 unicode-table parser. Table bytes go in
// through the push/full queue port, one per request; each accepted byte is run
// through a local parser model and the result popped from the block is
// compared field by field. Covers directed UTF-8 corner cases, glyph sizes,
// output backpressure and random font tables.
// ----------------------------------------------------------------------------
module psf2_unicode_table_parser_test;

  localparam int unsigned HOLD_CYCLES = 300;

  logic                                      clk = 1'b0;
  logic                                      rst_n;
  logic                                      cfg_valid;
  logic                                      cfg_ready;
  logic [psf2utp_pkg::GLYPH_BYTES_WIDTH-1:0] cfg_glyph_bytes;
  logic                                      push;
  logic                                      full;
  psf2utp_pkg::in_item_t                     in_item;
  logic                                      empty;
  logic                                      pop;
  psf2utp_pkg::out_item_t                    out_item;

  // parser model state
  logic [7:0]                                pend_bytes [4];
  logic [1:0]                                pend_cnt;
  logic [psf2utp_pkg::GLYPH_INDEX_WIDTH-1:0] glyph_idx;
  logic                                      parse_halted;
  logic                                      utf_error;
  logic                                      index_full;
  logic [psf2utp_pkg::GLYPH_BYTES_WIDTH-1:0] bitmap_bytes;

  psf2utp_pkg::out_item_t expected_entries [$];
  int unsigned bytes_sent;
  int unsigned errors;
  int unsigned pop_hold = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  bit          sender_steady;
  bit          receiver_steady;

  psf2_unicode_table_parser dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_glyph_bytes_i (cfg_glyph_bytes),
    .push              (push),
    .full              (full),
    .in_item_i         (in_item),
    .empty             (empty),
    .pop               (pop),
    .out_item_o        (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20_000_000;
    $display("** psf2_unicode_table_parser: FAILED **");
    $finish;
  end

  function automatic int unsigned utf8_length(input logic [7:0] lead);
    casez (lead)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  function automatic void clear_parser();
    for (int i = 0; i < 4; i++) pend_bytes[i] = 8'h00;
    pend_cnt     = '0;
    glyph_idx    = '0;
    parse_halted = 1'b0;
    utf_error    = 1'b0;
    index_full   = 1'b0;
  endfunction

  function automatic psf2utp_pkg::out_item_t parse_table_byte(
      input psf2utp_pkg::in_item_t it);
    psf2utp_pkg::out_item_t                  res;
    int unsigned                             n;
    int unsigned                             seq_len;
    logic [psf2utp_pkg::CODEPOINT_WIDTH-1:0] cp_acc;
    logic                                    ok;
    logic [31:0]                             prod;
    res = '0;
    if (!parse_halted) begin
      if (it.table_byte == psf2utp_pkg::SEQ_START_BYTE) begin
        parse_halted = 1'b1;
      end else if (it.table_byte == psf2utp_pkg::SEPARATOR_BYTE) begin
        // separator drops a half-built sequence as malformed
        if (pend_cnt != 0) begin
          utf_error = 1'b1;
          pend_cnt  = '0;
        end
        if (glyph_idx != psf2utp_pkg::GLYPH_INDEX_MAX) glyph_idx = glyph_idx + 1'b1;
        if (glyph_idx == psf2utp_pkg::GLYPH_INDEX_MAX) index_full = 1'b1;
      end else begin
        n = pend_cnt;
        pend_bytes[n] = it.table_byte;
        n = n + 1;
        seq_len = utf8_length(pend_bytes[0]);
        if (seq_len == 0) begin
          utf_error = 1'b1;
          pend_cnt  = '0;
        end else if (seq_len == n) begin
          ok = 1'b1;
          case (seq_len)
            1:       cp_acc = psf2utp_pkg::CODEPOINT_WIDTH'(pend_bytes[0]);
            2:       cp_acc = psf2utp_pkg::CODEPOINT_WIDTH'(pend_bytes[0][4:0]);
            3:       cp_acc = psf2utp_pkg::CODEPOINT_WIDTH'(pend_bytes[0][3:0]);
            default: cp_acc = psf2utp_pkg::CODEPOINT_WIDTH'(pend_bytes[0][2:0]);
          endcase
          for (int i = 1; i < seq_len; i++) begin
            if (pend_bytes[i][7:6] != 2'b10) ok = 1'b0;
            cp_acc = {cp_acc[psf2utp_pkg::CODEPOINT_WIDTH-7:0], pend_bytes[i][5:0]};
          end
          if (ok) begin
            prod              = 32'(glyph_idx) * 32'(bitmap_bytes);
            res.entry_valid   = 1'b1;
            res.codepoint     = cp_acc;
            res.glyph_offset  = prod[psf2utp_pkg::OFFSET_WIDTH-1:0];
          end else begin
            utf_error = 1'b1;
          end
          pend_cnt = '0;
        end else begin
          pend_cnt = n[1:0];
        end
      end
    end
    res.invalid_seen    = utf_error;
    res.sequence_stop   = parse_halted;
    res.index_saturated = index_full;
    if (it.end_of_table) clear_parser();
    return res;
  endfunction

  // Receiver: random pop, with an optional long hold-off counted here.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      pop_hold = HOLD_CYCLES;
    end
    if (pop_hold != 0) begin
      pop_hold = pop_hold - 1;
      pop <= 1'b0;
    end else begin
      pop <= receiver_steady || ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk) begin
    psf2utp_pkg::out_item_t want;
    if (rst_n && pop && !empty) begin
      if (expected_entries.size() == 0) begin
        errors++;
        $error("result popped with no request outstanding");
      end else begin
        want = expected_entries.pop_front();
        if (out_item.entry_valid !== want.entry_valid) begin
          errors++;
          $error("entry_valid: expected %0d, got %0d", want.entry_valid, out_item.entry_valid);
        end
        if (out_item.codepoint !== want.codepoint) begin
          errors++;
          $error("codepoint: expected %0h, got %0h", want.codepoint, out_item.codepoint);
        end
        if (out_item.glyph_offset !== want.glyph_offset) begin
          errors++;
          $error("glyph_offset: expected %0h, got %0h", want.glyph_offset,
                 out_item.glyph_offset);
        end
        if (out_item.invalid_seen !== want.invalid_seen) begin
          errors++;
          $error("invalid_seen: expected %0d, got %0d", want.invalid_seen,
                 out_item.invalid_seen);
        end
        if (out_item.sequence_stop !== want.sequence_stop) begin
          errors++;
          $error("sequence_stop: expected %0d, got %0d", want.sequence_stop,
                 out_item.sequence_stop);
        end
        if (out_item.index_saturated !== want.index_saturated) begin
          errors++;
          $error("index_saturated: expected %0d, got %0d", want.index_saturated,
                 out_item.index_saturated);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    psf2utp_pkg::in_item_t it;
    it.table_byte   = b;
    it.end_of_table = last;
    while (!sender_steady && $urandom_range(0, 99) < 20) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_entries.push_back(parse_table_byte(it));
    bytes_sent++;
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
  endtask

  task automatic write_glyph_bytes(input logic [psf2utp_pkg::GLYPH_BYTES_WIDTH-1:0] size);
    cfg_valid       <= 1'b1;
    cfg_glyph_bytes <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bitmap_bytes = size;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed glyph lists with random codepoints, plus some noise.
  task automatic send_random_table(input int unsigned n_tokens);
    logic [7:0]                              tbl_bytes [$];
    logic [psf2utp_pkg::CODEPOINT_WIDTH-1:0] cp;
    int unsigned                             r;
    int unsigned                             len;
    int unsigned                             keep;
    cp = '0;
    for (int t = 0; t < n_tokens; t++) begin
      r  = $urandom_range(0, 99);
      cp = psf2utp_pkg::CODEPOINT_WIDTH'($urandom());
      if (r < 60) begin
        len = $urandom_range(1, 4);
        case (len)
          1: tbl_bytes.push_back({1'b0, cp[6:0]});
          2: begin
            tbl_bytes.push_back({3'b110, cp[10:6]});
            tbl_bytes.push_back({2'b10, cp[5:0]});
          end
          3: begin
            tbl_bytes.push_back({4'b1110, cp[15:12]});
            tbl_bytes.push_back({2'b10, cp[11:6]});
            tbl_bytes.push_back({2'b10, cp[5:0]});
          end
          default: begin
            tbl_bytes.push_back({5'b11110, cp[20:18]});
            tbl_bytes.push_back({2'b10, cp[17:12]});
            tbl_bytes.push_back({2'b10, cp[11:6]});
            tbl_bytes.push_back({2'b10, cp[5:0]});
          end
        endcase
      end else if (r < 80) begin
        tbl_bytes.push_back(psf2utp_pkg::SEPARATOR_BYTE);
      end else if (r < 88) begin
        // truncated sequence cut by a separator or a stray ascii byte
        len  = $urandom_range(2, 4);
        keep = $urandom_range(0, len - 2);
        case (len)
          2:       tbl_bytes.push_back({3'b110, cp[4:0]});
          3:       tbl_bytes.push_back({4'b1110, cp[3:0]});
          default: tbl_bytes.push_back({5'b11110, cp[2:0]});
        endcase
        for (int k = 0; k < keep; k++) tbl_bytes.push_back({2'b10, cp[10:5]});
        tbl_bytes.push_back(cp[20] ? psf2utp_pkg::SEPARATOR_BYTE : {1'b0, cp[17:11]});
      end else if (r < 95) begin
        tbl_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 97) begin
        tbl_bytes.push_back(psf2utp_pkg::SEQ_START_BYTE);
      end else begin
        tbl_bytes.push_back({3'b110, cp[4:0]});
        tbl_bytes.push_back({cp[6] ? 2'b11 : 2'b00, cp[12:7]});
      end
    end
    foreach (tbl_bytes[i]) send_byte(tbl_bytes[i], i == tbl_bytes.size() - 1);
  endtask

  task automatic test_directed();
    logic [7:0] bytes_in [26];
    bytes_in = '{8'h00, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                 8'hF7, 8'hBF, 8'hBF, 8'hBF, psf2utp_pkg::SEPARATOR_BYTE, 8'hE2,
                 8'h41, 8'h80, 8'hF8, 8'hFD, 8'hC3, 8'h41, 8'hE2,
                 psf2utp_pkg::SEPARATOR_BYTE, psf2utp_pkg::SEQ_START_BYTE,
                 8'h41, psf2utp_pkg::SEPARATOR_BYTE};
    // table ends on a half-built sequence at 14, again while halted at 25
    foreach (bytes_in[i]) send_byte(bytes_in[i], (i == 14) || (i == 25));
    wait_results_drained();
  endtask

  task automatic test_glyph_sizes();
    logic [psf2utp_pkg::GLYPH_BYTES_WIDTH-1:0] sizes [4];
    sizes = '{'0, psf2utp_pkg::GLYPH_BYTES_WIDTH'(1),
              psf2utp_pkg::GLYPH_BYTES_WIDTH'(4096), '1};
    foreach (sizes[i]) begin
      write_glyph_bytes(sizes[i]);
      send_random_table(12);
      wait_results_drained();
    end
  endtask

  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_req++;
    send_random_table(40);
    wait_results_drained();
    sender_steady = 1'b0;
  endtask

  task automatic test_random_tables();
    logic [psf2utp_pkg::GLYPH_BYTES_WIDTH-1:0] sizes [5];
    int unsigned                               start;
    sizes = '{psf2utp_pkg::GLYPH_BYTES_WIDTH'(1), psf2utp_pkg::GLYPH_BYTES_WIDTH'(4096), '1,
              psf2utp_pkg::GLYPH_BYTES_WIDTH'($urandom_range(1, 4096)),
              psf2utp_pkg::GLYPH_BYTES_WIDTH'($urandom_range(2, 4095))};
    foreach (sizes[p]) begin
      // first phase runs with no gaps on either side
      sender_steady   = (p == 0);
      receiver_steady = (p == 0);
      write_glyph_bytes(sizes[p]);
      start = bytes_sent;
      while (bytes_sent - start < 300) send_random_table($urandom_range(5, 40));
      wait_results_drained();
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_glyph_bytes = '0;
    push            = 1'b0;
    pop             = 1'b0;
    in_item         = '0;
    errors          = 0;
    bytes_sent      = 0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    clear_parser();
    bitmap_bytes = psf2utp_pkg::GLYPH_BYTES_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_glyph_sizes();
    test_backpressure();
    test_random_tables();

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_entries.size() == 0) begin
      $display("** psf2_unicode_table_parser: PASSED **");
    end else begin
      $display("** psf2_unicode_table_parser: FAILED **");
    end
    $finish;
  end

endmodule
